// ===== rtl/core/iqr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iqr_pkg
// shared types and fixed constants of the linear interpolation i/q resampler
// ----------------------------------------------------------------------------
package iqr_pkg;

    localparam int DataW   = 16;
    localparam int CfgW    = 14;
    localparam int StepMax = 16383;
    localparam int MaxRes  = 4;
    localparam int ResCntW = 2;
    // quotient of the offset numerator, including the 2^16 bias
    localparam int QuoW    = 17;

    localparam logic [CfgW-1:0] CfgReset = 14'd2500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_I,
        S_MUL_Q,
        S_DIV,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/iqr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iqr_if
// valid/ready channels of the resampler: sample in, result out, config write
// ----------------------------------------------------------------------------
interface iqr_in_if;
    import iqr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] i_sample;
    logic signed [DataW-1:0] q_sample;
    modport source (output valid, output i_sample, output q_sample, input ready);
    modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

interface iqr_out_if;
    import iqr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] i_out;
    logic signed [DataW-1:0] q_out;
    logic                    block_end;
    logic                    last;
    modport source (output valid, output i_out, output q_out, output block_end,
                    output last, input ready);
    modport sink   (input valid, input i_out, input q_out, input block_end,
                    input last, output ready);
endinterface

interface iqr_cfg_if;
    import iqr_pkg::*;
    logic            valid;
    logic            ready;
    logic [CfgW-1:0] samples_per_block;
    modport source (output valid, output samples_per_block, input ready);
    modport sink   (input valid, input samples_per_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/iqr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iqr_div
// divider by the constant 2*OUT_LEN through reciprocal multiplication,
// i lane then q lane on one constant multiplier
// ----------------------------------------------------------------------------
module iqr_div #(
    parameter int OUT_LEN = 2400,
    localparam int DivW = $clog2(2 * OUT_LEN + 1),
    localparam int NumW = iqr_pkg::QuoW + DivW
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [NumW-1:0]          i_num_i,
    input  wire logic [NumW-1:0]          i_num_q,
    output logic                          o_done,
    output logic [iqr_pkg::QuoW-1:0]      o_quo_i,
    output logic [iqr_pkg::QuoW-1:0]      o_quo_q
);
    import iqr_pkg::*;

    // exact floor division for every numerator below 2^NumW whose quotient fits in QuoW bits
    localparam int     ShW      = $clog2(2 * OUT_LEN);
    localparam int     RecW     = NumW + 1;
    localparam int     PrdW     = NumW + RecW;
    localparam longint RecipVal =
        ((longint'(1) <<< (NumW + ShW)) + longint'(2 * OUT_LEN) - 1) / longint'(2 * OUT_LEN);
    localparam logic [RecW-1:0] Recip = RecW'(RecipVal);

    logic            r_busy;
    logic            r_lane;
    logic            r_done;
    logic [QuoW-1:0] r_quo_i;
    logic [QuoW-1:0] r_quo_q;
    logic [NumW-1:0] w_num;
    logic [PrdW-1:0] w_prod;
    logic [QuoW-1:0] w_quo;

    assign w_num  = r_lane ? i_num_q : i_num_i;
    assign w_prod = PrdW'(w_num) * PrdW'(Recip);
    assign w_quo  = w_prod[NumW+ShW +: QuoW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_lane <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_lane <= 1'b0;
            end else if (r_busy) begin
                r_lane <= 1'b1;
                if (r_lane) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !r_lane) begin
            r_quo_i <= w_quo;
        end
        if (r_busy && r_lane) begin
            r_quo_q <= w_quo;
        end
    end

    assign o_done  = r_done;
    assign o_quo_i = r_quo_i;
    assign o_quo_q = r_quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/linear_interp_iq_resampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_iq_resampler
// converts samples_per_block i/q samples per ms to OUT_LEN per ms by linear
// interpolation with an exact phase and round-to-nearest fixed point blend
// ----------------------------------------------------------------------------
// channel  dir  payload                          beat when
// i_in     in   i_sample, q_sample               valid & ready
// o_out    out  i_out, q_out, block_end, last    valid & ready
// i_cfg    in   samples_per_block                valid & ready (always ready)
//
// a sample that gives no result is taken in S_IDLE; each result steps through
// S_MUL_I and S_MUL_Q on the one multiplier, the reciprocal divider by
// 2*OUT_LEN (start, i lane, q lane, done), then the output register load
// a sample gives up to 4 results; i_in is ready only in S_IDLE
// synchronous active-low reset; samples_per_block resets to 2500
// a stalled output holds the sequencer before the next result load
// ----------------------------------------------------------------------------
module linear_interp_iq_resampler #(
    parameter int OUT_LEN = 2400
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    iqr_in_if.sink    i_in,
    iqr_out_if.source o_out,
    iqr_cfg_if.sink   i_cfg
);
    import iqr_pkg::*;

    localparam int PhW   = $clog2(OUT_LEN + StepMax);
    localparam int WgtW  = $clog2(OUT_LEN);
    localparam int IdxW  = $clog2(OUT_LEN);
    localparam int DivW  = $clog2(2 * OUT_LEN + 1);
    localparam int NumW  = QuoW + DivW;
    localparam int DiffW = DataW + 1;
    localparam int ProdW = DiffW + WgtW + 1;
    localparam int MinStep = (OUT_LEN + MaxRes - 1) / MaxRes;

    localparam logic [PhW-1:0]  PhLen   = PhW'(OUT_LEN);
    localparam logic [IdxW-1:0] IdxLast = IdxW'(OUT_LEN - 1);
    localparam logic [CfgW-1:0] StepMin = CfgW'(MinStep);
    localparam logic [ResCntW-1:0] ResLast = ResCntW'(MaxRes - 1);
    localparam logic signed [NumW:0] Bias =
        (NumW + 1)'(2 * OUT_LEN * 65536 + OUT_LEN);

    t_state                   r_state, n_state;
    logic [CfgW-1:0]          r_cfg;
    logic [CfgW-1:0]          r_step, n_step;
    logic signed [DataW-1:0]  r_prev_i, n_prev_i, r_prev_q, n_prev_q;
    logic signed [DataW-1:0]  r_cur_i, n_cur_i, r_cur_q, n_cur_q;
    logic                     r_have_prev, n_have_prev;
    logic [PhW-1:0]           r_phase, n_phase;
    logic [IdxW-1:0]          r_oidx, n_oidx;
    logic [ResCntW-1:0]       r_cnt, n_cnt;
    logic [NumW-1:0]          r_num_i, n_num_i, r_num_q, n_num_q;
    logic                     r_div_start, n_div_start;
    logic                     r_out_valid, n_out_valid;
    logic signed [DataW-1:0]  r_out_i, n_out_i, r_out_q, n_out_q;
    logic                     r_out_be, n_out_be;
    logic                     r_out_last, n_out_last;

    logic                     w_in_beat;
    logic                     w_out_free;
    logic [CfgW-1:0]          w_step_eff;
    logic [PhW-1:0]           w_phase_add;
    logic                     w_last;
    logic signed [DiffW-1:0]  w_diff_i, w_diff_q, w_diff;
    logic signed [ProdW-1:0]  w_prod;
    logic signed [NumW:0]     w_prod_ext;
    logic signed [NumW:0]     w_num;
    logic                     w_div_done;
    logic [QuoW-1:0]          w_quo_i, w_quo_q;

    iqr_div #(
        .OUT_LEN (OUT_LEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num_i (r_num_i),
        .i_num_q (r_num_q),
        .o_done  (w_div_done),
        .o_quo_i (w_quo_i),
        .o_quo_q (w_quo_q)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_beat   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_step_eff  = (r_cfg < StepMin) ? StepMin : r_cfg;
    assign w_phase_add = r_phase + PhW'(r_step);
    assign w_last      = (w_phase_add >= PhLen) || (r_cnt == ResLast);

    // shared multiplier: sample difference times phase weight, offset to stay positive
    assign w_diff_i   = DiffW'(r_cur_i) - DiffW'(r_prev_i);
    assign w_diff_q   = DiffW'(r_cur_q) - DiffW'(r_prev_q);
    assign w_diff     = (r_state == S_MUL_I) ? w_diff_i : w_diff_q;
    assign w_prod     = ProdW'(w_diff) * ProdW'($signed({1'b0, r_phase[WgtW-1:0]}));
    assign w_prod_ext = (NumW + 1)'(w_prod);
    assign w_num      = (w_prod_ext <<< 1) + Bias;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_prev_i    = r_prev_i;
        n_prev_q    = r_prev_q;
        n_cur_i     = r_cur_i;
        n_cur_q     = r_cur_q;
        n_have_prev = r_have_prev;
        n_phase     = r_phase;
        n_oidx      = r_oidx;
        n_cnt       = r_cnt;
        n_num_i     = r_num_i;
        n_num_q     = r_num_q;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_i     = r_out_i;
        n_out_q     = r_out_q;
        n_out_be    = r_out_be;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    if (!r_have_prev) begin
                        n_prev_i    = i_in.i_sample;
                        n_prev_q    = i_in.q_sample;
                        n_have_prev = 1'b1;
                    end else if (r_phase < PhLen) begin
                        n_cur_i = i_in.i_sample;
                        n_cur_q = i_in.q_sample;
                        n_step  = w_step_eff;
                        n_cnt   = '0;
                        n_state = S_MUL_I;
                    end else begin
                        n_phase  = r_phase - PhLen;
                        n_prev_i = i_in.i_sample;
                        n_prev_q = i_in.q_sample;
                    end
                end
            end
            S_MUL_I: begin
                n_num_i = w_num[NumW-1:0];
                n_state = S_MUL_Q;
            end
            S_MUL_Q: begin
                n_num_q     = w_num[NumW-1:0];
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_i     = r_prev_i + $signed(w_quo_i[DataW-1:0]);
                    n_out_q     = r_prev_q + $signed(w_quo_q[DataW-1:0]);
                    n_out_be    = (r_oidx == IdxLast);
                    n_out_last  = w_last;
                    n_oidx      = (r_oidx == IdxLast) ? '0 : r_oidx + 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (w_last) begin
                        n_phase  = (w_phase_add >= PhLen) ? w_phase_add - PhLen : '0;
                        n_prev_i = r_cur_i;
                        n_prev_q = r_cur_q;
                        n_state  = S_IDLE;
                    end else begin
                        n_phase = w_phase_add;
                        n_state = S_MUL_I;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CfgReset;
            r_prev_i    <= '0;
            r_prev_q    <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_oidx      <= '0;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.samples_per_block;
            end
            r_prev_i    <= n_prev_i;
            r_prev_q    <= n_prev_q;
            r_have_prev <= n_have_prev;
            r_phase     <= n_phase;
            r_oidx      <= n_oidx;
            r_cnt       <= n_cnt;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_cur_i    <= n_cur_i;
        r_cur_q    <= n_cur_q;
        r_num_i    <= n_num_i;
        r_num_q    <= n_num_q;
        r_out_i    <= n_out_i;
        r_out_q    <= n_out_q;
        r_out_be   <= n_out_be;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.i_out     = r_out_i;
    assign o_out.q_out     = r_out_q;
    assign o_out.block_end = r_out_be;
    assign o_out.last      = r_out_last;

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_oidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oidx <= IdxLast)
        else $error("output index out of range");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_I || r_state == S_MUL_Q) |-> (r_phase < PhLen))
        else $error("interpolation weight out of range");

    a_first_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> r_have_prev)
        else $error("sample beat did not leave a previous sample");
`endif

endmodule
`default_nettype wire

// ===== test/linear_interp_iq_resampler_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_iq_resampler_tb
// self-checking bench for the i/q resampler: a queue-fed driver offers
// samples, a scoreboard model predicts every interpolated output with its
// block_end and last flags, and a monitor compares each output beat in order.
// the run steps through several samples_per_block settings, from 0 to 16383,
// with random stalls on either side and one long output hold-off.
// ----------------------------------------------------------------------------
module linear_interp_iq_resampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iqr_pkg::*;

    localparam int OutLen       = 2400;
    localparam int MinStep      = (OutLen + MaxRes - 1) / MaxRes;
    localparam int NumPhases    = 12;
    localparam int HoldPhase    = 8;
    localparam int HoldCycles   = 600;
    localparam int SettleCycles = 200;
    localparam int MaxReports   = 10;
    localparam longint TimeoutNs = 6_000_000;

    typedef struct packed {
        logic signed [DataW-1:0] i_val;
        logic signed [DataW-1:0] q_val;
    } t_iq_in;

    typedef struct packed {
        logic signed [DataW-1:0] i_out;
        logic signed [DataW-1:0] q_out;
        logic                    block_end;
        logic                    last;
    } t_iq_out;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    iqr_in_if  in_if ();
    iqr_out_if out_if ();
    iqr_cfg_if cfg_if ();

    linear_interp_iq_resampler #(
        .OUT_LEN (OutLen)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expected outputs
    t_iq_in  sample_q[$];
    t_iq_out interp_out_q[$];

    // scoreboard copy of the resampler state
    logic signed [DataW-1:0] held_i    = '0;
    logic signed [DataW-1:0] held_q    = '0;
    logic                    primed    = 1'b0;
    logic [14:0]             frac_pos  = '0;
    logic [11:0]             out_count = '0;
    logic [CfgW-1:0]         spb_reg   = CfgReset;

    int send_idle = 0;
    int recv_idle = 0;
    logic hold_go = 1'b0;
    int hold_cnt = 0;

    int n_err = 0;
    int n_samples = 0;
    int n_out = 0;
    int n_block_end = 0;
    int n_cfg = 0;

    int walk_i = 0;
    int walk_q = 0;

    function automatic void note_error(input string msg);
        n_err++;
        if (n_err <= MaxReports) begin
            $display("%s", msg);
        end
    endfunction

    // (a*(L-p) + b*p)/L, nearest, ties toward plus infinity
    function automatic logic signed [DataW-1:0] interp(input logic signed [DataW-1:0] a,
                                                       input logic signed [DataW-1:0] b,
                                                       input longint p);
        longint x;
        longint q;
        x = longint'(a) * (OutLen - p) + longint'(b) * p;
        q = (2 * (x + 32768 * OutLen) + OutLen) / (2 * OutLen);
        q = q - 32768;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return q[DataW-1:0];
    endfunction

    task automatic resample_step(input logic signed [DataW-1:0] cur_i,
                                 input logic signed [DataW-1:0] cur_q);
        int unsigned stride;
        int n;
        t_iq_out r;
        stride = (spb_reg < MinStep) ? MinStep : spb_reg;
        if (!primed) begin
            held_i = cur_i;
            held_q = cur_q;
            primed = 1'b1;
            return;
        end
        n = 0;
        while (frac_pos < OutLen && n < MaxRes) begin
            r.i_out     = interp(held_i, cur_i, longint'(frac_pos));
            r.q_out     = interp(held_q, cur_q, longint'(frac_pos));
            r.block_end = (out_count == OutLen - 1);
            out_count   = (out_count == OutLen - 1) ? '0 : out_count + 1'b1;
            frac_pos    = frac_pos + stride[14:0];
            n++;
            r.last      = !(frac_pos < OutLen && n < MaxRes);
            interp_out_q.push_back(r);
        end
        if (frac_pos >= OutLen) begin
            frac_pos = frac_pos - OutLen[14:0];
        end else begin
            frac_pos = '0;
        end
        held_i = cur_i;
        held_q = cur_q;
    endtask

    task automatic push_iq(input logic [DataW-1:0] iv, input logic [DataW-1:0] qv);
        t_iq_in s;
        s.i_val = iv;
        s.q_val = qv;
        sample_q.push_back(s);
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic logic [DataW-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // mostly a random walk (a plausible signal), some full-range noise and extremes
    task automatic push_random(input int count);
        int k;
        int sel;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                walk_i = clamp16(walk_i + int'($urandom_range(4095)) - 2048);
                walk_q = clamp16(walk_q + int'($urandom_range(4095)) - 2048);
                push_iq(walk_i[DataW-1:0], walk_q[DataW-1:0]);
            end else if (sel < 85) begin
                push_iq(DataW'($urandom_range(16'hffff)), DataW'($urandom_range(16'hffff)));
            end else begin
                push_iq(pick_extreme(), pick_extreme());
            end
        end
    endtask

    task automatic write_spb(input logic [CfgW-1:0] v);
        @(posedge i_clk);
        cfg_if.valid             <= 1'b1;
        cfg_if.samples_per_block <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        spb_reg = v;
        n_cfg++;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || in_if.valid || interp_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        t_iq_in s;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                resample_step(in_if.i_sample, in_if.q_sample);
                n_samples++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s = sample_q.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.i_sample <= s.i_val;
                    in_if.q_sample <= s.q_val;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_go && hold_cnt < HoldCycles) begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_iq_out want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_out++;
                if (out_if.block_end) begin
                    n_block_end++;
                end
                if (interp_out_q.size() == 0) begin
                    note_error($sformatf("unexpected output beat: i=%0d q=%0d end=%0b last=%0b",
                                         out_if.i_out, out_if.q_out,
                                         out_if.block_end, out_if.last));
                end else begin
                    want = interp_out_q.pop_front();
                    if (out_if.i_out !== want.i_out || out_if.q_out !== want.q_out ||
                        out_if.block_end !== want.block_end || out_if.last !== want.last) begin
                        note_error($sformatf({"output %0d: expected i=%0d q=%0d end=%0b ",
                                              "last=%0b, got i=%0d q=%0d end=%0b last=%0b"},
                            n_out, want.i_out, want.q_out, want.block_end, want.last,
                            out_if.i_out, out_if.q_out, out_if.block_end, out_if.last));
                    end
                end
            end
            out_if.ready <= !(hold_go && hold_cnt < HoldCycles) &&
                            ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #(TimeoutNs);
        $display("linear_interp_iq_resampler_tb NOT OK");
        $finish;
    end

    initial begin
        int ph;
        int len;
        logic [CfgW-1:0] spb;
        in_if.valid              = 1'b0;
        in_if.i_sample           = '0;
        in_if.q_sample           = '0;
        out_if.ready             = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.samples_per_block = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < NumPhases; ph++) begin
            len = 25;
            spb = CfgReset;
            case (ph)
                1:  begin spb = 14'd600;   len = 80;  end
                2:  begin spb = 14'd16383; len = 40;  end
                3:  begin spb = 14'd2400;  len = 20;  end
                4:  begin spb = 14'd0;     len = 60;  end
                5:  begin spb = CfgW'($urandom_range(599, 1)); len = 60; end
                6:  begin spb = 14'd601;   len = 35;  end
                7:  begin spb = 14'd4799;  len = 20;  end
                8:  begin spb = 14'd600;   len = 100; end
                9:  spb = CfgW'($urandom_range(16383, 600));
                10: spb = CfgW'($urandom_range(16383, 0));
                default: ;
            endcase
            // the first phase runs on the reset value of the register
            if (ph != 0) begin
                write_spb(spb);
            end
            @(negedge i_clk);
            if (ph < 4) begin
                send_idle = 21;
                recv_idle = 46;
            end else if (ph < 8) begin
                send_idle = 46;
                recv_idle = 21;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == HoldPhase) begin
                hold_go = 1'b1;
            end
            if (ph == 0) begin
                // first sample only primes, then full-scale swings, bit patterns, a tie
                push_iq(16'h0000, 16'h0000);
                push_iq(16'h7fff, 16'h8000);
                push_iq(16'h8000, 16'h7fff);
                push_iq(16'h7fff, 16'h7fff);
                push_iq(16'h8000, 16'h8000);
                push_iq(16'h7fff, 16'h8000);
                push_iq(16'h0000, 16'hffff);
                push_iq(16'h5555, 16'haaaa);
                push_iq(16'haaaa, 16'h5555);
                push_iq(16'h0001, 16'hffff);
                push_iq(16'hffff, 16'h0001);
                push_iq(16'h7fff, 16'h7fff);
                push_iq(16'h0000, 16'h0000);
                push_iq(16'h0001, 16'hffff);
                push_iq(16'hffff, 16'h0001);
                push_iq(16'h8000, 16'h7fff);
                len = 20;
            end
            push_random(len);
            drain();
        end

        n_err = n_err + interp_out_q.size();
        $display("covered %0d samples and %0d output beats over %0d register writes",
                 n_samples, n_out, n_cfg);
        $display("saw %0d block ends, %0d failures", n_block_end, n_err);
        if (n_err == 0) begin
            $display("linear_interp_iq_resampler_tb OK");
        end else begin
            $display("linear_interp_iq_resampler_tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
